// ===== hdl/kps_pkg.sv =====
// ----------------------------------------------------------------------------
// kps_pkg
// Shared types and constants for the descending key/tag sorter.
// ----------------------------------------------------------------------------
`default_nettype none

package kps_pkg;

    localparam int KEY_W           = 32;
    localparam int TAG_W           = 8;
    localparam int ENTRY_W         = KEY_W + TAG_W;
    localparam int MAX_ENTRIES_DEF = 32;

    // one stored entry: signed key and its tag
    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [TAG_W-1:0]        tag;
    } t_entry;

endpackage

`default_nettype wire

// ===== hdl/key_payload_sorter_descending.sv =====
// Loading: one transfer per cycle; busy stays low between non-last entries.
// On the last entry the block goes busy, bubble-sorts the held set of N entries
// through one compare unit and one RAM port pair, in at most N-1 passes,
// stopping early after a pass with no swap. Results then follow, each one
// read from the RAM and then strobed on o_valid.
// Synchronous active-low reset clears count, overflow flag and sequencer only.
// ----------------------------------------------------------------------------
// key_payload_sorter_descending
// Collects signed keys with tags, sorts them in descending, stable order on
// the last entry and emits them in rank order with an overflow flag.
// ----------------------------------------------------------------------------
`default_nettype none

module key_payload_sorter_descending #(
    parameter int MAX_ENTRIES = kps_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic signed [kps_pkg::KEY_W-1:0] i_key_in,
    input  wire logic [kps_pkg::TAG_W-1:0]        i_tag_in,
    input  wire logic                            i_last_in,
    output logic                                 o_valid,
    output logic signed [kps_pkg::KEY_W-1:0]      o_key_out,
    output logic [kps_pkg::TAG_W-1:0]             o_tag_out,
    output logic                                 o_last_out,
    output logic                                 o_overflow
);

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    // sequencer codes
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD0   = 3'd1;
    localparam logic [2:0] S_FIRST = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_CMP   = 3'd4;
    localparam logic [2:0] S_PEND  = 3'd5;
    localparam logic [2:0] S_ORD   = 3'd6;
    localparam logic [2:0] S_OEM   = 3'd7;

    logic [2:0]      r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic            r_drop, n_drop;
    logic [AW-1:0]   r_j, n_j;
    logic [AW-1:0]   r_end, n_end;
    logic [AW-1:0]   r_k, n_k;
    kps_pkg::t_entry r_a, n_a;
    logic            r_swapped, n_swapped;

    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    kps_pkg::t_entry              ram_wdata;
    logic [AW-1:0]                ram_raddr;
    logic [kps_pkg::ENTRY_W-1:0]  ram_rdata;
    kps_pkg::t_entry              rd_entry;

    logic            accept;
    logic            full;
    logic [AW-1:0]   count_m1;
    logic [AW-1:0]   j_p1;

    assign rd_entry = kps_pkg::t_entry'(ram_rdata);
    assign accept   = start && !busy;
    assign full     = (r_count == CW'(MAX_ENTRIES));
    assign count_m1 = AW'(r_count - CW'(1));
    assign j_p1     = AW'(r_j + AW'(1));

    // entry store
    kps_ram #(
        .WIDTH (kps_pkg::ENTRY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // sequencer: load, bubble passes with a carried entry, then read out
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_drop    = r_drop;
        n_j       = r_j;
        n_end     = r_end;
        n_k       = r_k;
        n_a       = r_a;
        n_swapped = r_swapped;
        ram_we    = 1'b0;
        ram_waddr = r_j;
        ram_wdata = r_a;
        ram_raddr = r_k;

        unique case (r_state)
            S_IDLE: begin
                ram_waddr     = r_count[AW-1:0];
                ram_wdata.key = i_key_in;
                ram_wdata.tag = i_tag_in;
                if (accept) begin
                    if (!full) begin
                        ram_we  = 1'b1;
                        n_count = CW'(r_count + CW'(1));
                    end else begin
                        n_drop = 1'b1;
                    end
                    if (i_last_in) begin
                        n_k = '0;
                        if (!full && r_count != '0) begin
                            // at least two entries once this one is held
                            n_end   = r_count[AW-1:0];
                            n_state = S_RD0;
                        end else if (full) begin
                            n_end   = AW'(MAX_ENTRIES - 1);
                            n_state = S_RD0;
                        end else begin
                            n_state = S_ORD;
                        end
                    end
                end
            end
            S_RD0: begin
                ram_raddr = '0;
                n_state   = S_FIRST;
            end
            S_FIRST: begin
                n_a       = rd_entry;
                n_j       = '0;
                n_swapped = 1'b0;
                n_state   = S_READ;
            end
            S_READ: begin
                ram_raddr = j_p1;
                n_state   = S_CMP;
            end
            S_CMP: begin
                // swap only on strict less-than, keeps equal keys in order
                ram_we    = 1'b1;
                ram_waddr = r_j;
                if (r_a.key < rd_entry.key) begin
                    ram_wdata = rd_entry;
                    n_swapped = 1'b1;
                end else begin
                    ram_wdata = r_a;
                    n_a       = rd_entry;
                end
                if (j_p1 == r_end) begin
                    n_state = S_PEND;
                end else begin
                    n_j     = j_p1;
                    n_state = S_READ;
                end
            end
            S_PEND: begin
                ram_we    = 1'b1;
                ram_waddr = r_end;
                ram_wdata = r_a;
                if (r_end == AW'(1) || !r_swapped) begin
                    n_k     = '0;
                    n_state = S_ORD;
                end else begin
                    n_end   = AW'(r_end - AW'(1));
                    n_state = S_RD0;
                end
            end
            S_ORD: begin
                ram_raddr = r_k;
                n_state   = S_OEM;
            end
            S_OEM: begin
                if (r_k == count_m1) begin
                    n_count = '0;
                    n_drop  = 1'b0;
                    n_state = S_IDLE;
                end else begin
                    n_k     = AW'(r_k + AW'(1));
                    n_state = S_ORD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_drop  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_drop  <= n_drop;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_j       <= n_j;
        r_end     <= n_end;
        r_k       <= n_k;
        r_a       <= n_a;
        r_swapped <= n_swapped;
    end

    // result ports
    assign busy       = (r_state != S_IDLE);
    assign o_valid    = (r_state == S_OEM);
    assign o_key_out  = rd_entry.key;
    assign o_tag_out  = rd_entry.tag;
    assign o_last_out = (r_k == count_m1);
    assign o_overflow = r_drop;

    // checks
    a_valid_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result strobe outside busy period");

    a_count_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ENTRIES))
        else $error("entry count beyond capacity");

    a_last_ends : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_out) |=> (!busy && r_count == '0 && !r_drop))
        else $error("set state not cleared after final result");

    a_last_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_last_in) |=> busy)
        else $error("last transfer did not start sorting");

    a_pass_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> (r_j < r_end && (full || r_end < r_count[AW-1:0])))
        else $error("compare index outside held entries");

endmodule

`default_nettype wire

// ===== hdl/kps_ram.sv =====
// ----------------------------------------------------------------------------
// kps_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module kps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= mem[i_raddr];
    end

endmodule

`default_nettype wire
